// ----- rtl/core/dff_pkg.sv -----
// Shared types and sizes for the duplicate frame filter.
`timescale 1ns / 1ps

package dff_pkg;

  localparam int SOURCES       = 3;
  localparam int HISTORY_DEPTH = 5;
  localparam int ADDR_W        = 32;
  localparam int SEQ_W         = 8;
  localparam int SRC_W         = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam logic [SEQ_W-1:0] ERASED_SEQ = 8'hFF;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SRC_W-1:0]  src_idx_t;
  typedef logic [SLOT_W-1:0] slot_idx_t;

  // Lookup outcome for one word, handed from the match logic to the table update.
  typedef struct packed {
    logic      addr_hit;
    src_idx_t  entry;
    logic      seq_hit;
    slot_idx_t slot_new;
  } match_t;

endpackage

// ----- rtl/core/dff_match.sv -----
// Address and sequence lookup against the history table.
`timescale 1ns / 1ps

module dff_match (
  input  dff_pkg::addr_t     addr,
  input  dff_pkg::seq_t      seq,
  input  dff_pkg::addr_t     src_table [dff_pkg::SOURCES],
  input  dff_pkg::seq_t      seq_table [dff_pkg::SOURCES][dff_pkg::HISTORY_DEPTH],
  input  dff_pkg::slot_idx_t slot_ptr  [dff_pkg::SOURCES],
  input  dff_pkg::src_idx_t  replace_ptr,
  output dff_pkg::match_t    result
);

  logic              hit;
  dff_pkg::src_idx_t hit_idx;
  dff_pkg::src_idx_t victim;
  dff_pkg::src_idx_t entry;
  logic              row_hit;
  logic [dff_pkg::SLOT_W:0] slot_inc;

  // Lowest matching entry wins: scan downwards so the last assignment is the lowest.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int e = dff_pkg::SOURCES - 1; e >= 0; e--) begin
      if (src_table[e] == addr) begin
        hit     = 1'b1;
        hit_idx = dff_pkg::SRC_W'(e);
      end
    end
  end

  always_comb begin
    if ({1'b0, replace_ptr} >= (dff_pkg::SRC_W + 1)'(dff_pkg::SOURCES - 1)) begin
      victim = '0;
    end else begin
      victim = replace_ptr + 1'b1;
    end
  end

  assign entry = hit ? hit_idx : victim;

  always_comb begin
    row_hit = 1'b0;
    for (int s = 0; s < dff_pkg::HISTORY_DEPTH; s++) begin
      if (seq_table[entry][s] == seq) begin
        row_hit = 1'b1;
      end
    end
  end

  assign slot_inc = {1'b0, slot_ptr[entry]} + 1'b1;

  always_comb begin
    result.addr_hit = hit;
    result.entry    = entry;
    // a fresh entry holds only erased slots
    result.seq_hit  = hit ? row_hit : (seq == dff_pkg::ERASED_SEQ);
    if (slot_inc >= (dff_pkg::SLOT_W + 1)'(dff_pkg::HISTORY_DEPTH)) begin
      result.slot_new = '0;
    end else begin
      result.slot_new = slot_inc[dff_pkg::SLOT_W-1:0];
    end
  end

endmodule

// ----- rtl/core/duplicate_frame_filter.sv -----
// Top level of the duplicate frame filter: input register, table state, result register.
// A word taken into the input register gives its result on done through the result register.
// Throughput: one word per cycle; busy is never raised, and the lookup is combinational.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (synchronous): addresses and sequence slots to zero, slot pointers to zero,
// replace pointer to the last entry; no clearing pass is needed.
`timescale 1ns / 1ps

module duplicate_frame_filter (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dff_pkg::addr_t src_addr,
  input  dff_pkg::seq_t  seq_num,
  output logic           done,
  output logic           is_duplicate
);

  logic              in_valid;
  dff_pkg::addr_t    in_addr;
  dff_pkg::seq_t     in_seq;

  dff_pkg::addr_t     src_table [dff_pkg::SOURCES];
  dff_pkg::seq_t      seq_table [dff_pkg::SOURCES][dff_pkg::HISTORY_DEPTH];
  dff_pkg::slot_idx_t slot_ptr  [dff_pkg::SOURCES];
  dff_pkg::src_idx_t  replace_ptr;

  dff_pkg::match_t   lookup;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_addr <= src_addr;
    in_seq  <= seq_num;
  end

  dff_match u_match (
    .addr        (in_addr),
    .seq         (in_seq),
    .src_table   (src_table),
    .seq_table   (seq_table),
    .slot_ptr    (slot_ptr),
    .replace_ptr (replace_ptr),
    .result      (lookup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_ptr <= dff_pkg::SRC_W'(dff_pkg::SOURCES - 1);
      for (int e = 0; e < dff_pkg::SOURCES; e++) begin
        src_table[e] <= '0;
        slot_ptr[e]  <= '0;
        for (int s = 0; s < dff_pkg::HISTORY_DEPTH; s++) begin
          seq_table[e][s] <= '0;
        end
      end
    end else if (in_valid) begin
      if (!lookup.addr_hit) begin
        replace_ptr                <= lookup.entry;
        src_table[lookup.entry]    <= in_addr;
      end
      for (int s = 0; s < dff_pkg::HISTORY_DEPTH; s++) begin
        // new sequence goes in at the advanced slot, the rest of a replaced row is erased
        if (!lookup.seq_hit && (dff_pkg::slot_idx_t'(s) == lookup.slot_new)) begin
          seq_table[lookup.entry][s] <= in_seq;
        end else if (!lookup.addr_hit) begin
          seq_table[lookup.entry][s] <= dff_pkg::ERASED_SEQ;
        end
      end
      if (!lookup.seq_hit) begin
        slot_ptr[lookup.entry] <= lookup.slot_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    is_duplicate <= lookup.seq_hit;
  end

endmodule

// ----- verif/tb_duplicate_frame_filter.sv -----
// Self-checking testbench for the duplicate frame filter.
`timescale 1ns / 1ps

module tb_duplicate_frame_filter;

  localparam int CYCLE_LIMIT  = 50000;
  localparam int RANDOM_WORDS = 400;
  localparam int CALM_WORDS   = 100;
  localparam int ADDR_POOL    = 5;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  dff_pkg::addr_t src_addr;
  dff_pkg::seq_t  seq_num;
  logic           done;
  logic           is_duplicate;

  // Predicted table contents
  dff_pkg::addr_t addr_tab [dff_pkg::SOURCES];
  dff_pkg::seq_t  hist_tab [dff_pkg::SOURCES][dff_pkg::HISTORY_DEPTH];
  int             slot_ptr [dff_pkg::SOURCES];
  int             repl_ptr;

  bit             dup_flags_due[$];
  int             fail_count;
  int             cycle_count;
  bit             gaps_on;
  dff_pkg::addr_t addr_pool [ADDR_POOL];

  duplicate_frame_filter DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .src_addr     (src_addr),
    .seq_num      (seq_num),
    .done         (done),
    .is_duplicate (is_duplicate)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_history_table();
    for (int i = 0; i < dff_pkg::SOURCES; i++) begin
      addr_tab[i] = '0;
      slot_ptr[i] = 0;
      for (int j = 0; j < dff_pkg::HISTORY_DEPTH; j++) hist_tab[i][j] = '0;
    end
    repl_ptr = dff_pkg::SOURCES - 1;
  endfunction

  function automatic bit predict_duplicate(dff_pkg::addr_t a, dff_pkg::seq_t s);
    int e;
    int p;
    e = -1;
    for (int i = 0; i < dff_pkg::SOURCES; i++) begin
      if (e < 0 && addr_tab[i] == a) e = i;
    end
    if (e < 0) begin
      // miss: next entry round-robin, slots erased, slot pointer kept
      repl_ptr = (repl_ptr + 1) % dff_pkg::SOURCES;
      e = repl_ptr;
      addr_tab[e] = a;
      for (int j = 0; j < dff_pkg::HISTORY_DEPTH; j++) hist_tab[e][j] = dff_pkg::ERASED_SEQ;
    end
    for (int j = 0; j < dff_pkg::HISTORY_DEPTH; j++) begin
      if (hist_tab[e][j] == s) return 1'b1;
    end
    p = (slot_ptr[e] + 1) % dff_pkg::HISTORY_DEPTH;
    slot_ptr[e] = p;
    hist_tab[e][p] = s;
    return 1'b0;
  endfunction

  // Present one word from the falling edge until it is taken
  task automatic send_word(input dff_pkg::addr_t a, input dff_pkg::seq_t s);
    bit took;
    @(negedge clk);
    start    = 1'b1;
    src_addr = a;
    seq_num  = s;
    do begin
      @(posedge clk);
      took = !busy;
    end while (!took);
    dup_flags_due.push_back(predict_duplicate(a, s));
  endtask

  task automatic maybe_gap();
    int n;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
  endtask

  task automatic test_reset_contents();
    // every entry holds address zero with zeroed slots
    send_word('0, 8'd0);
    send_word('0, 8'd0);
    send_word('0, 8'd7);
    send_word('0, 8'd7);
  endtask

  task automatic test_erased_slots();
    // 255 straight after a replacement hits the erased slots
    send_word('1, 8'hFF);
    send_word('1, 8'd0);
    send_word('1, 8'd0);
    send_word('1, 8'hFF);
  endtask

  task automatic test_ring_wrap();
    for (int i = 1; i <= dff_pkg::HISTORY_DEPTH + 1; i++) begin
      send_word(32'h1234_5678, dff_pkg::seq_t'(i));
    end
    send_word(32'h1234_5678, 8'd1);
    send_word(32'h1234_5678, dff_pkg::seq_t'(dff_pkg::HISTORY_DEPTH + 1));
  endtask

  task automatic test_replacement();
    send_word(32'hA5A5_0001, 8'h55);
    send_word(32'h5A5A_0002, 8'hAA);
    send_word(32'h8000_0000, 8'h80);
    send_word(32'h1234_5678, 8'd2);
    send_word('1, 8'd0);
  endtask

  task automatic test_random_traffic();
    dff_pkg::addr_t a;
    dff_pkg::seq_t  s;
    for (int i = 0; i < ADDR_POOL; i++) addr_pool[i] = dff_pkg::addr_t'($urandom);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      gaps_on = (i < RANDOM_WORDS - CALM_WORDS) && ((i / 40) % 3 != 2);
      if ($urandom_range(0, 9) < 8) a = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
      else a = dff_pkg::addr_t'($urandom);
      case ($urandom_range(0, 9))
        0:       s = 8'hFF;
        1, 2:    s = dff_pkg::seq_t'($urandom);
        default: s = dff_pkg::seq_t'($urandom_range(0, 11));
      endcase
      send_word(a, s);
      maybe_gap();
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (dup_flags_due.size() == 0) begin
        $error("is_duplicate: result with none expected, actual %0d", is_duplicate);
        fail_count++;
      end else begin
        if (is_duplicate !== dup_flags_due[0]) begin
          $error("is_duplicate: expected %0d, actual %0d", dup_flags_due[0], is_duplicate);
          fail_count++;
        end
        void'(dup_flags_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    gaps_on     = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    src_addr    = '0;
    seq_num     = '0;
    clear_history_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_contents();
    test_erased_slots();
    test_ring_wrap();
    test_replacement();
    test_random_traffic();

    @(negedge clk);
    start = 1'b0;
    while (dup_flags_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
